// ===== hw/rtl/prv_pkg.sv =====
`default_nettype none

package prv_pkg;

	// Default number of playback channels.
	localparam int CHANNELS_DEF = 8;

	// Field widths fixed by the interface.
	localparam int SOUND_W  = 8;
	localparam int PRIO_W   = 2;
	localparam int MS_W     = 16;
	localparam int COUNT_W  = 9;
	localparam int CH_FLD_W = 5;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_WINDOW = 2'd1;
	localparam logic [1:0] REG_COUNT  = 2'd2;

	// Reset values of the registers.
	localparam logic              ENABLE_RST = 1'b1;
	localparam logic [MS_W-1:0]   WINDOW_RST = 16'd50;
	localparam logic [COUNT_W-1:0] COUNT_RST = 9'd64;

	// Request priorities.
	localparam logic [PRIO_W-1:0] PRIO_LOWEST  = 2'd0;
	localparam logic [PRIO_W-1:0] PRIO_LOW     = 2'd1;
	localparam logic [PRIO_W-1:0] PRIO_HIGH    = 2'd2;
	localparam logic [PRIO_W-1:0] PRIO_HIGHEST = 2'd3;

	// Request kinds.
	localparam logic REQ_PLAY = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_PLAYED      = 3'd0,
		ST_DISABLED    = 3'd1,
		ST_BAD_ID      = 3'd2,
		ST_RECENT_DUP  = 3'd3,
		ST_ALREADY     = 3'd4,
		ST_ALL_SAME    = 3'd5,
		ST_NONE_FREE   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_TICK,
		S_DECIDE
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/priority_voice_allocator.sv =====
`default_nettype none

// Priority voice allocator. Play requests and one-millisecond ticks enter on the
// slave stream; every play request yields one result word on the master stream,
// a tick yields none. A small sequencer walks the channel table one channel per
// cycle through a single shared compare unit. A play request holds the input
// through the accepting cycle, one scan cycle per channel, then a decision
// cycle that also writes the chosen channel; a request refused for being
// disabled or for a bad id goes from accept straight to decide, and a tick,
// after the accept, updates one channel per cycle. The result sits in an
// output register, so a new item is taken while an earlier result still waits;
// the decision cycle stalls only when a second result is ready before the first
// was taken.
// Configuration goes through the APB-style port at byte addresses 0 (audio
// enable), 4 (duplicate window in ms) and 8 (valid sound count), and is to be
// written only while the block is idle.
module priority_voice_allocator #(
	parameter int CHANNELS = prv_pkg::CHANNELS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// Request stream.
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// [7:0] sound_id, [9:8] priority_req, [25:10] sound_length_ms, rest zero.
	input  wire logic [prv_pkg::DATA_W-1:0] s_tdata,
	// [0] req_type.
	input  wire logic [0:0]                 s_tuser,
	// Result stream.
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// [0] accepted, [5:1] channel, [8:6] status, rest zero.
	output logic [15:0]                     m_tdata,
	// Configuration port.
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [prv_pkg::ADDR_W-1:0] paddr,
	input  wire logic [prv_pkg::DATA_W-1:0] pwdata,
	output logic [prv_pkg::DATA_W-1:0]      prdata,
	output logic                            pready
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW = prv_pkg::SOUND_W;
	localparam int PW = prv_pkg::PRIO_W;
	localparam int MW = prv_pkg::MS_W;

	// Configuration registers.
	logic                          enable_q;
	logic [MW-1:0]                 window_q;
	logic [prv_pkg::COUNT_W-1:0]   count_q;

	// Channel table.
	logic          playing_q [CHANNELS];
	logic          loaded_q  [CHANNELS];
	logic [SW-1:0] sound_q   [CHANNELS];
	logic [PW-1:0] prio_ch_q [CHANNELS];
	logic [MW-1:0] elapsed_q [CHANNELS];
	logic [MW-1:0] length_q  [CHANNELS];

	// Sequencer and the latched request.
	prv_pkg::state_t  state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic [SW-1:0]    id_q;
	logic [PW-1:0]    prio_q;
	logic [MW-1:0]    len_q;
	logic             pre_rej_q;
	prv_pkg::status_t pre_code_q;

	// Scan findings.
	logic             dup_q, same_play_q;
	logic             idle_found_q, diff_found_q, take_found_q;
	logic [IDX_W-1:0] idle_idx_q, diff_idx_q, take_idx_q;

	// Output register.
	logic                         out_valid_q;
	logic                         out_acc_q;
	logic [prv_pkg::CH_FLD_W-1:0] out_ch_q;
	prv_pkg::status_t             out_st_q;

	logic in_fire, out_free, idx_last, cfg_wr;
	logic [SW-1:0] in_id;
	logic [PW-1:0] in_prio;
	logic [MW-1:0] in_len;

	// Shared per-channel compare unit.
	logic          c_play, c_same, c_dup, c_take;
	logic [MW-1:0] c_elapsed_inc;

	// Decision.
	logic             dec_acc;
	logic [IDX_W-1:0] dec_ch;
	prv_pkg::status_t dec_st;
	logic             dec_load;

	assign in_id    = s_tdata[7:0];
	assign in_prio  = s_tdata[9:8];
	assign in_len   = s_tdata[25:10];
	assign s_tready = (state_q == prv_pkg::S_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign idx_last = (idx_q == IDX_W'(CHANNELS - 1));
	assign dec_load = (state_q == prv_pkg::S_DECIDE) && out_free;

	// APB-style configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= prv_pkg::ENABLE_RST;
			window_q <= prv_pkg::WINDOW_RST;
			count_q  <= prv_pkg::COUNT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				prv_pkg::REG_ENABLE: enable_q <= pwdata[0];
				prv_pkg::REG_WINDOW: window_q <= pwdata[MW-1:0];
				prv_pkg::REG_COUNT:  count_q  <= pwdata[prv_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			prv_pkg::REG_ENABLE: prdata = {31'd0, enable_q};
			prv_pkg::REG_WINDOW: prdata = {16'd0, window_q};
			prv_pkg::REG_COUNT:  prdata = {23'd0, count_q};
			default:             prdata = '0;
		endcase
	end

	// Compare unit: looks at the channel under the scan index.
	always_comb begin
		c_play = playing_q[idx_q];
		c_same = loaded_q[idx_q] && (sound_q[idx_q] == id_q);
		c_dup  = c_play && c_same && (elapsed_q[idx_q] <= window_q);
		c_take = (prio_ch_q[idx_q] < prv_pkg::PRIO_HIGH) ||
		         ((prio_ch_q[idx_q] == prv_pkg::PRIO_HIGH) && !c_play);
		c_elapsed_inc = (elapsed_q[idx_q] == {MW{1'b1}}) ? elapsed_q[idx_q]
		                                                 : elapsed_q[idx_q] + 1'b1;
	end

	// Decision from the scan findings. The order of the tests matches the order
	// in which a request is refused.
	always_comb begin
		dec_acc = 1'b0;
		dec_ch  = '0;
		dec_st  = prv_pkg::ST_NONE_FREE;
		if (pre_rej_q) begin
			dec_st = pre_code_q;
		end else if ((prio_q < prv_pkg::PRIO_HIGH) && dup_q) begin
			dec_st = prv_pkg::ST_RECENT_DUP;
		end else if (prio_q == prv_pkg::PRIO_HIGHEST) begin
			if (idle_found_q) begin
				dec_acc = 1'b1;
				dec_ch  = idle_idx_q;
				dec_st  = prv_pkg::ST_PLAYED;
			end else if (diff_found_q) begin
				dec_acc = 1'b1;
				dec_ch  = diff_idx_q;
				dec_st  = prv_pkg::ST_PLAYED;
			end else begin
				dec_st = prv_pkg::ST_ALL_SAME;
			end
		end else if (((prio_q == prv_pkg::PRIO_LOWEST) || (prio_q == prv_pkg::PRIO_HIGH))
		             && same_play_q) begin
			dec_st = prv_pkg::ST_ALREADY;
		end else if (prio_q != prv_pkg::PRIO_HIGH) begin
			if (idle_found_q) begin
				dec_acc = 1'b1;
				dec_ch  = idle_idx_q;
				dec_st  = prv_pkg::ST_PLAYED;
			end
		end else if (take_found_q) begin
			dec_acc = 1'b1;
			dec_ch  = take_idx_q;
			dec_st  = prv_pkg::ST_PLAYED;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prv_pkg::S_IDLE: begin
				if (in_fire) begin
					if (s_tuser[0] == prv_pkg::REQ_TICK) begin
						state_d = prv_pkg::S_TICK;
					end else if (!enable_q || ({1'b0, in_id} >= count_q)) begin
						state_d = prv_pkg::S_DECIDE;
					end else begin
						state_d = prv_pkg::S_SCAN;
					end
				end
			end
			prv_pkg::S_SCAN: begin
				if (idx_last) state_d = prv_pkg::S_DECIDE;
			end
			prv_pkg::S_TICK: begin
				if (idx_last) state_d = prv_pkg::S_IDLE;
			end
			prv_pkg::S_DECIDE: begin
				if (out_free) state_d = prv_pkg::S_IDLE;
			end
			default: state_d = prv_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prv_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request latch, scan index and findings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			pre_rej_q    <= 1'b0;
			pre_code_q   <= prv_pkg::ST_PLAYED;
			dup_q        <= 1'b0;
			same_play_q  <= 1'b0;
			idle_found_q <= 1'b0;
			diff_found_q <= 1'b0;
			take_found_q <= 1'b0;
			idle_idx_q   <= '0;
			diff_idx_q   <= '0;
			take_idx_q   <= '0;
			id_q         <= '0;
			prio_q       <= '0;
			len_q        <= '0;
		end else if (in_fire) begin
			idx_q        <= '0;
			id_q         <= in_id;
			prio_q       <= in_prio;
			len_q        <= in_len;
			pre_rej_q    <= !enable_q || ({1'b0, in_id} >= count_q);
			pre_code_q   <= !enable_q ? prv_pkg::ST_DISABLED : prv_pkg::ST_BAD_ID;
			dup_q        <= 1'b0;
			same_play_q  <= 1'b0;
			idle_found_q <= 1'b0;
			diff_found_q <= 1'b0;
			take_found_q <= 1'b0;
		end else if (state_q == prv_pkg::S_SCAN) begin
			idx_q <= idx_q + 1'b1;
			if (c_dup) dup_q <= 1'b1;
			if (c_play && c_same) same_play_q <= 1'b1;
			if (!c_play && !idle_found_q) begin
				idle_found_q <= 1'b1;
				idle_idx_q   <= idx_q;
			end
			if (!c_same && !diff_found_q) begin
				diff_found_q <= 1'b1;
				diff_idx_q   <= idx_q;
			end
			if (c_take && !take_found_q) begin
				take_found_q <= 1'b1;
				take_idx_q   <= idx_q;
			end
		end else if (state_q == prv_pkg::S_TICK) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Channel table: a tick ages one channel a cycle; a decision writes the
	// chosen channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				playing_q[i] <= 1'b0;
				loaded_q[i]  <= 1'b0;
				sound_q[i]   <= '0;
				prio_ch_q[i] <= '0;
				elapsed_q[i] <= '0;
				length_q[i]  <= '0;
			end
		end else if ((state_q == prv_pkg::S_TICK) && c_play) begin
			elapsed_q[idx_q] <= c_elapsed_inc;
			if (c_elapsed_inc >= length_q[idx_q]) playing_q[idx_q] <= 1'b0;
		end else if (dec_load && dec_acc) begin
			playing_q[dec_ch] <= 1'b1;
			loaded_q[dec_ch]  <= 1'b1;
			sound_q[dec_ch]   <= id_q;
			prio_ch_q[dec_ch] <= prio_q;
			elapsed_q[dec_ch] <= '0;
			length_q[dec_ch]  <= len_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_acc_q   <= 1'b0;
			out_ch_q    <= '0;
			out_st_q    <= prv_pkg::ST_PLAYED;
		end else if (dec_load) begin
			out_valid_q <= 1'b1;
			out_acc_q   <= dec_acc;
			out_ch_q    <= dec_acc ? prv_pkg::CH_FLD_W'(dec_ch) : '0;
			out_st_q    <= dec_st;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_st_q, out_ch_q, out_acc_q};

	// An accepted result always reports a played status, a refused one never.
	a_acc_status : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_acc_q == (out_st_q == prv_pkg::ST_PLAYED)))
		else $error("accepted flag and status disagree");

	// A refused result carries channel zero.
	a_rej_chan : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_acc_q) |-> (out_ch_q == '0))
		else $error("refused result with nonzero channel");

	// An assigned channel exists and is playing right after the assignment.
	a_assign_play : assert property (@(posedge clk) disable iff (!arst_n)
		(dec_load && dec_acc) |=> (int'(out_ch_q) < CHANNELS) &&
		                          playing_q[$past(dec_ch)])
		else $error("assigned channel not playing");

	// A tick never produces a result: after it is taken the output does not rise.
	a_tick_silent : assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (s_tuser[0] == prv_pkg::REQ_TICK)) |=> !$rose(out_valid_q))
		else $error("tick produced a result");

	// The scan index never leaves the channel table while scanning.
	a_idx_range : assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == prv_pkg::S_SCAN) || (state_q == prv_pkg::S_TICK)) |->
		(int'(idx_q) < CHANNELS))
		else $error("scan index out of range");

endmodule

`default_nettype wire
